// ----- rtl/ipv4cs_pkg.sv -----
// Shared widths, field positions and types for the IPv4 header checksum inserter.
package ipv4cs_pkg;

    localparam int LANE_W    = 64;
    localparam int NUM_LANES = 8;
    localparam int BEAT_W    = LANE_W * NUM_LANES;
    localparam int KEEP_W    = 64;
    localparam int DATA_W    = BEAT_W + KEEP_W;
    localparam int HDR_WORDS = 10;
    localparam int HDR_W     = HDR_WORDS * 16;
    localparam int CSUM_W    = 16;
    // byte 10 carries the checksum high half, byte 11 the low half
    localparam int CSUM_HI_POS = 80;
    localparam int CSUM_LO_POS = 88;

    typedef logic [BEAT_W-1:0] t_beat;
    typedef logic [KEEP_W-1:0] t_keep;
    typedef logic [HDR_W-1:0]  t_hdr;
    typedef logic [CSUM_W-1:0] t_csum;

endpackage

// ----- rtl/ipv4cs_csum.sv -----
// One's-complement checksum over the 20-byte IPv4 header of a beat.
module ipv4cs_csum (
    input  ipv4cs_pkg::t_hdr  i_hdr,
    output ipv4cs_pkg::t_csum o_csum
);
    import ipv4cs_pkg::*;

    logic [15:0] w [HDR_WORDS];
    logic [16:0] s_pair [HDR_WORDS/2];
    logic [17:0] s_a;
    logic [17:0] s_b;
    logic [18:0] s_c;
    logic [19:0] s_total;
    logic [16:0] s_fold1;
    logic [15:0] s_fold2;

    // big-endian words: lower-numbered byte is the high half
    always_comb begin
        for (int i = 0; i < HDR_WORDS; i++) begin
            w[i] = {i_hdr[16*i +: 8], i_hdr[16*i+8 +: 8]};
        end
        for (int i = 0; i < HDR_WORDS/2; i++) begin
            s_pair[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        end
    end

    assign s_a     = {1'b0, s_pair[0]} + {1'b0, s_pair[1]};
    assign s_b     = {1'b0, s_pair[2]} + {1'b0, s_pair[3]};
    assign s_c     = {1'b0, s_a} + {1'b0, s_b};
    assign s_total = {1'b0, s_c} + {3'b000, s_pair[4]};

    // two end-around folds bring a 20-bit sum down to 16 bits
    assign s_fold1 = {1'b0, s_total[15:0]} + {13'd0, s_total[19:16]};
    assign s_fold2 = s_fold1[15:0] + {15'd0, s_fold1[16]};

    assign o_csum = ~s_fold2;

endmodule

// ----- rtl/ipv4_header_checksum_insert.sv -----
// Top level: IPv4 header checksum insertion on a 512-bit stream.
//
// Usage:
//   s_axis carries beats in, m_axis carries them out; an item moves when
//   tvalid and tready are both high. tdata packs the beat (bits 511:0, byte k
//   at 8k+7:8k) and the byte keep mask (bits 575:512); tlast ends a packet.
//   On the first beat of every packet bytes 10 and 11 are replaced by the
//   one's-complement checksum of bytes 0..19; all other bits, keep and last
//   pass through unchanged. A beat with tlast set makes the next beat a
//   first beat again.
//   The item is captured in the input register on the accepting edge and then
//   moves to the result register, which drives m_axis_tvalid.
//   Throughput: one beat per cycle while the receiver does not stall; the
//   checksum adder tree between the two registers is combinational.
//   Reset (i_rst_n low, synchronous) empties both registers and arms the
//   first-beat flag. When the receiver stalls, the result register holds its
//   item and the input register still takes one more, after which
//   s_axis_tready drops until m_axis_tready returns.
module ipv4_header_checksum_insert (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // lane0..lane7 (bits 511:0), byte_keep (bits 575:512)
    input  logic [ipv4cs_pkg::DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_lane0..out_lane7 (bits 511:0), out_keep (bits 575:512)
    output logic [ipv4cs_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);
    import ipv4cs_pkg::*;

    logic  r_at_first;
    logic  r_in_valid;
    t_beat r_in_beat;
    t_keep r_in_keep;
    logic  r_in_last;
    logic  r_in_first;
    logic  r_out_valid;
    t_beat r_out_beat;
    t_keep r_out_keep;
    logic  r_out_last;

    logic  pipe_en;
    logic  in_accept;
    t_csum csum;
    t_beat n_out_beat;

    assign pipe_en       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || pipe_en;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_first <= 1'b1;
        end else if (in_accept) begin
            // rearm on the last item of a packet
            r_at_first <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (pipe_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_beat  <= s_axis_tdata[BEAT_W-1:0];
            r_in_keep  <= s_axis_tdata[DATA_W-1:BEAT_W];
            r_in_last  <= s_axis_tlast;
            r_in_first <= r_at_first;
        end
    end

    ipv4cs_csum u_csum (
        .i_hdr  (r_in_beat[HDR_W-1:0]),
        .o_csum (csum)
    );

    always_comb begin
        n_out_beat = r_in_beat;
        if (r_in_first) begin
            n_out_beat[CSUM_HI_POS +: 8] = csum[15:8];
            n_out_beat[CSUM_LO_POS +: 8] = csum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_in_valid) begin
            r_out_beat <= n_out_beat;
            r_out_keep <= r_in_keep;
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_keep, r_out_beat};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_rearm_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && s_axis_tlast |=> r_at_first)
        else $error("first-beat flag not rearmed after last item");

    a_clear_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !s_axis_tlast |=> !r_at_first)
        else $error("first-beat flag still set inside a packet");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !pipe_en |=> r_in_valid && $stable(r_in_beat))
        else $error("input register lost an item during a stall");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && pipe_en |=> r_out_valid)
        else $error("item did not reach the result register");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking stream testbench for the IPv4 header checksum inserter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4cs_pkg::*;

    localparam int NUM_ITEMS   = 1300;
    localparam int MAX_GAP     = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        t_beat beat;
        t_keep keep;
        logic  last;
    } t_egress;

    typedef struct packed {
        logic [HDR_W-1:0] hdr;   // header bytes, byte 0 in the top bits
        t_beat            fill;  // bytes 20..63
        t_keep            keep;
        logic             last;
        logic             typed; // checksum below is known by hand
        t_csum            csum;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;  // beat (511:0), keep (575:512)
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;       // beat (511:0), keep (575:512)
    logic                  m_axis_tlast;

    // side info that travels with the item being offered
    logic  drv_typed = 1'b0;
    t_csum drv_csum = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_items = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_packets = 0;
    int n_single = 0;
    int cycle_cnt = 0;
    logic at_pkt_start = 1'b1;
    t_egress egress_q[$];
    t_dir_row dir_rows[$];

    ipv4_header_checksum_insert DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One's-complement sum of bytes 0..19 as big-endian words, folded fully, inverted.
    function automatic t_csum header_csum(input t_beat b);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < HDR_WORDS; i++) begin
            acc += {16'h0, b[16*i +: 8], b[16*i+8 +: 8]};
        end
        while (acc > 32'h0000_FFFF) begin
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        end
        return ~acc[15:0];
    endfunction

    function automatic t_beat hdr_beat(input logic [HDR_W-1:0] hdr, input t_beat fill);
        t_beat r;
        r = fill;
        for (int k = 0; k < HDR_W / 8; k++) begin
            r[8*k +: 8] = hdr[HDR_W-1-8*k -: 8];
        end
        return r;
    endfunction

    function automatic t_beat rand_beat();
        t_beat r;
        for (int i = 0; i < BEAT_W / 32; i++) begin
            r[32*i +: 32] = $urandom;
        end
        return r;
    endfunction

    function automatic t_keep rand_keep();
        return {$urandom, $urandom};
    endfunction

    // Receiver: stall at random per cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on every accepted input item, check every accepted output item.
    always @(posedge i_clk) begin
        t_egress exp_e;
        t_egress got;
        t_csum   csum;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                exp_e.beat = s_axis_tdata[BEAT_W-1:0];
                exp_e.keep = s_axis_tdata[DATA_W-1:BEAT_W];
                exp_e.last = s_axis_tlast;
                if (at_pkt_start) begin
                    csum = drv_typed ? drv_csum : header_csum(exp_e.beat);
                    exp_e.beat[CSUM_HI_POS +: 8] = csum[15:8];
                    exp_e.beat[CSUM_LO_POS +: 8] = csum[7:0];
                    n_packets++;
                    if (s_axis_tlast) n_single++;
                end
                // a last beat re-arms the first-beat flag
                at_pkt_start = s_axis_tlast;
                egress_q.push_back(exp_e);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.beat = m_axis_tdata[BEAT_W-1:0];
                got.keep = m_axis_tdata[DATA_W-1:BEAT_W];
                got.last = m_axis_tlast;
                if (egress_q.size() == 0) begin
                    $display("%0t ns: unexpected output item, expected none, actual %h last %b",
                             $time, got.beat, got.last);
                    n_errors++;
                end else begin
                    exp_e = egress_q.pop_front();
                    n_checked++;
                    for (int n = 0; n < NUM_LANES; n++) begin
                        if (got.beat[LANE_W*n +: LANE_W] !== exp_e.beat[LANE_W*n +: LANE_W]) begin
                            $display("%0t ns: lane%0d mismatch, expected %h, actual %h", $time, n,
                                     exp_e.beat[LANE_W*n +: LANE_W], got.beat[LANE_W*n +: LANE_W]);
                            n_errors++;
                        end
                    end
                    if (got.keep !== exp_e.keep) begin
                        $display("%0t ns: keep mismatch, expected %h, actual %h",
                                 $time, exp_e.keep, got.keep);
                        n_errors++;
                    end
                    if (got.last !== exp_e.last) begin
                        $display("%0t ns: last mismatch, expected %b, actual %b",
                                 $time, exp_e.last, got.last);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d items still expected",
                     $time, cycle_cnt, egress_q.size());
            $display("** ipv4_header_checksum_insert: FAILED **");
            $finish;
        end
    end

    // Offer one item at the falling edge and hold it until accepted.
    task automatic send_beat(input t_beat b, input t_keep k, input logic last,
                             input logic typed, input t_csum c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {k, b};
        s_axis_tlast  <= last;
        drv_typed     <= typed;
        drv_csum      <= c;
        n_items++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly short packets; half of the first beats carry a plausible header.
    task automatic send_random_packet();
        int    nbeats;
        int    kind;
        t_beat b;
        t_keep k;
        t_csum c;
        nbeats = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 8);
        for (int i = 0; i < nbeats; i++) begin
            b = rand_beat();
            k = '1;
            if (i == 0) begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0: begin
                        b[HDR_W-1:0] = '1;
                    end
                    1: begin
                        b[HDR_W-1:0] = '0;
                    end
                    2, 3, 4, 5: begin
                        b[7:0] = 8'h45;
                        b[CSUM_HI_POS +: CSUM_W] = '0;
                    end
                    6: begin
                        // header already carrying its valid checksum
                        b[7:0] = 8'h45;
                        b[CSUM_HI_POS +: CSUM_W] = '0;
                        c = header_csum(b);
                        b[CSUM_HI_POS +: 8] = c[15:8];
                        b[CSUM_LO_POS +: 8] = c[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i == nbeats - 1) begin
                k = ($urandom_range(0, 3) == 0) ? rand_keep()
                                                : ({KEEP_W{1'b1}} >> $urandom_range(0, 63));
            end else if ($urandom_range(0, 19) == 0) begin
                k = rand_keep();
            end
            send_beat(b, k, i == nbeats - 1, 1'b0, '0);
        end
    endtask

    initial begin
        t_beat fill_a;
        t_beat fill_b;
        fill_a = {(BEAT_W / 8){8'h5A}};
        fill_b = {(BEAT_W / 8){8'hC3}};

        // hdr, fill, keep, last, typed, csum
        dir_rows.push_back('{'0, '0, '0, 1'b1, 1'b1, 16'hFFFF});
        dir_rows.push_back('{'1, '1, '1, 1'b1, 1'b1, 16'h0000});
        dir_rows.push_back('{160'h4500_0073_0000_4000_4011_0000_c0a8_0001_c0a8_00c7,
                             fill_a, '1, 1'b0, 1'b1, 16'hB861});
        dir_rows.push_back('{'1, '1, '1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{'0, '0, 64'h0000_0000_0000_000F, 1'b1, 1'b0, '0});
        dir_rows.push_back('{160'h4500_0073_0000_4000_4011_b861_c0a8_0001_c0a8_00c7,
                             fill_b, '1, 1'b1, 1'b1, 16'h0000});
        // carry out of the first fold needs a second fold
        dir_rows.push_back('{160'hffff_ffff_0001_0000_0000_0000_0000_0000_0000_0000,
                             '0, '1, 1'b1, 1'b1, 16'hFFFE});
        // options present: only the first 20 bytes count
        dir_rows.push_back('{160'h4600_0018_abcd_0000_4006_0000_0a00_0001_0a00_0002,
                             fill_a, '1, 1'b1, 1'b0, '0});
        // keep does not gate the sum
        dir_rows.push_back('{160'h4500_0073_0000_4000_4011_0000_c0a8_0001_c0a8_00c7,
                             fill_b, '0, 1'b1, 1'b1, 16'hB861});
        // stale checksum field is part of the sum
        dir_rows.push_back('{160'h0000_0000_0000_0000_0000_1234_0000_0000_0000_0000,
                             '0, 64'h0000_0000_0000_0001, 1'b0, 1'b1, 16'hEDCB});
        dir_rows.push_back('{160'h0000_0000_0000_0000_0000_aabb_0000_0000_0000_0000,
                             fill_a, '1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{'1, fill_b, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, '0});
        dir_rows.push_back('{160'h8000_0000_0000_0000_0000_0000_0000_0000_0000_0001,
                             '1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 32;
        recv_idle_pct = 83;
        foreach (dir_rows[i]) begin
            send_beat(hdr_beat(dir_rows[i].hdr, dir_rows[i].fill), dir_rows[i].keep,
                      dir_rows[i].last, dir_rows[i].typed, dir_rows[i].csum);
        end
        while (n_items < NUM_ITEMS / 3) send_random_packet();
        send_idle_pct = 83;
        recv_idle_pct = 32;
        while (n_items < 2 * NUM_ITEMS / 3) send_random_packet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (n_items < NUM_ITEMS) send_random_packet();
        s_axis_tvalid <= 1'b0;

        while (egress_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d output items from %0d packets (%0d single-beat), header checksums",
                 n_checked, n_packets, n_single);
        $display("and pass-through under heavy sender idling, heavy receiver stalls and none.");
        if (n_errors == 0) begin
            $display("** ipv4_header_checksum_insert: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** ipv4_header_checksum_insert: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ipv4cs_pkg.sv
rtl/ipv4cs_csum.sv
rtl/ipv4_header_checksum_insert.sv
tb/sv/testbench.sv
